FILE: design/pdc_pkg.sv
package pdc_pkg;

    typedef enum logic [1:0] {
        PH_ID  = 2'd0,
        PH_LEN = 2'd1,
        PH_PAY = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SUM  = 2'd1,
        ST_ZERO_LEN = 2'd2
    } status_t;

    localparam int unsigned DATA_W = 8;

    typedef struct packed {
        logic [DATA_W-1:0] byte_out;
        logic              is_param;
        logic [DATA_W-1:0] param_index;
        logic [DATA_W-1:0] pkt_id;
        logic              end_of_packet;
        status_t           status;
    } result_t;

endpackage

FILE: design/pdc_rx_if.sv
interface pdc_rx_if;
    logic                          valid;
    logic                          ready;
    logic [pdc_pkg::DATA_W-1:0]    rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: design/pdc_res_if.sv
interface pdc_res_if;
    logic                          valid;
    logic                          ready;
    logic [pdc_pkg::DATA_W-1:0]    byte_out;
    logic                          is_param;
    logic [pdc_pkg::DATA_W-1:0]    param_index;
    logic [pdc_pkg::DATA_W-1:0]    pkt_id;
    logic                          end_of_packet;
    logic [1:0]                    status;

    modport source (
        output valid, output byte_out, output is_param, output param_index,
        output pkt_id, output end_of_packet, output status, input ready
    );
    modport sink (
        input valid, input byte_out, input is_param, input param_index,
        input pkt_id, input end_of_packet, input status, output ready
    );
endinterface

FILE: design/pdc_input_reg.sv
module pdc_input_reg (
    input  logic                       clk,
    input  logic                       rst_n,
    pdc_rx_if.sink                     rx,
    input  logic                       advance,
    output logic                       item_valid,
    output logic [pdc_pkg::DATA_W-1:0] item_byte
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [pdc_pkg::DATA_W-1:0] byte_reg;
    logic                       take;

    // take a new word when empty or when the held word moves on
    assign rx.ready = !valid_reg || advance;
    assign take     = rx.valid && rx.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= rx.rx_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

endmodule

FILE: design/pdc_frame_fsm.sv
module pdc_frame_fsm (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic [pdc_pkg::DATA_W-1:0] item_byte,
    output pdc_pkg::result_t           res
);

    pdc_pkg::phase_t            phase_reg;
    pdc_pkg::phase_t            phase_next;
    logic [pdc_pkg::DATA_W-1:0] current_id_reg;
    logic [pdc_pkg::DATA_W-1:0] current_id_next;
    logic [pdc_pkg::DATA_W-1:0] expected_len_reg;
    logic [pdc_pkg::DATA_W-1:0] expected_len_next;
    logic [pdc_pkg::DATA_W-1:0] bytes_seen_reg;
    logic [pdc_pkg::DATA_W-1:0] bytes_seen_next;
    logic [pdc_pkg::DATA_W-1:0] running_sum_reg;
    logic [pdc_pkg::DATA_W-1:0] running_sum_next;
    logic [pdc_pkg::DATA_W-1:0] seen_inc;
    logic [pdc_pkg::DATA_W-1:0] sum_add;
    logic                       last_byte;

    assign seen_inc  = bytes_seen_reg + pdc_pkg::DATA_W'(1);
    assign sum_add   = running_sum_reg + item_byte;
    assign last_byte = (seen_inc == expected_len_reg);

    // next state
    always_comb
    begin
        phase_next        = phase_reg;
        current_id_next   = current_id_reg;
        expected_len_next = expected_len_reg;
        bytes_seen_next   = bytes_seen_reg;
        running_sum_next  = running_sum_reg;
        unique case (phase_reg)
            pdc_pkg::PH_LEN:
            begin
                expected_len_next = item_byte;
                running_sum_next  = sum_add;
                bytes_seen_next   = '0;
                phase_next        = (item_byte == '0) ? pdc_pkg::PH_ID : pdc_pkg::PH_PAY;
            end
            pdc_pkg::PH_PAY:
            begin
                if (last_byte)
                begin
                    phase_next = pdc_pkg::PH_ID;
                end
                else
                begin
                    running_sum_next = sum_add;
                    bytes_seen_next  = seen_inc;
                end
            end
            default:
            begin
                current_id_next   = item_byte;
                running_sum_next  = item_byte;
                expected_len_next = '0;
                bytes_seen_next   = '0;
                phase_next        = pdc_pkg::PH_LEN;
            end
        endcase
    end

    // result for the word in the input register
    always_comb
    begin
        res               = '0;
        res.byte_out      = item_byte;
        res.pkt_id        = current_id_reg;
        res.status        = pdc_pkg::ST_OK;
        unique case (phase_reg)
            pdc_pkg::PH_LEN:
            begin
                if (item_byte == '0)
                begin
                    res.end_of_packet = 1'b1;
                    res.status        = pdc_pkg::ST_ZERO_LEN;
                end
            end
            pdc_pkg::PH_PAY:
            begin
                if (last_byte)
                begin
                    res.end_of_packet = 1'b1;
                    res.status        = (~running_sum_reg == item_byte) ?
                                        pdc_pkg::ST_OK : pdc_pkg::ST_BAD_SUM;
                end
                else
                begin
                    res.is_param    = 1'b1;
                    res.param_index = bytes_seen_reg;
                end
            end
            default:
            begin
                res.pkt_id = item_byte;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= pdc_pkg::PH_ID;
            current_id_reg   <= '0;
            expected_len_reg <= '0;
            bytes_seen_reg   <= '0;
            running_sum_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg        <= phase_next;
            current_id_reg   <= current_id_next;
            expected_len_reg <= expected_len_next;
            bytes_seen_reg   <= bytes_seen_next;
            running_sum_reg  <= running_sum_next;
        end
    end

    a_id_starts_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && phase_reg == pdc_pkg::PH_ID) |=>
        (phase_reg == pdc_pkg::PH_LEN && running_sum_reg == $past(item_byte)))
        else $error("id word did not seed the sum");

    a_len_to_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && phase_reg == pdc_pkg::PH_LEN && item_byte != '0) |=>
        (phase_reg == pdc_pkg::PH_PAY && expected_len_reg == $past(item_byte)))
        else $error("non-zero length did not enter payload");

    a_param_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.is_param) |=>
        (bytes_seen_reg == $past(bytes_seen_reg) + pdc_pkg::DATA_W'(1)))
        else $error("parameter word not counted");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(phase_reg) && $stable(running_sum_reg)))
        else $error("state moved without a word");

endmodule

FILE: design/pdc_result_reg.sv
module pdc_result_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  pdc_pkg::result_t res_in,
    output logic             free,
    pdc_res_if.source        result
);

    logic             valid_reg;
    logic             valid_next;
    pdc_pkg::result_t data_reg;

    // free when empty or when the held word leaves this cycle
    assign free = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res_in;
        end
    end

    assign result.valid         = valid_reg;
    assign result.byte_out      = data_reg.byte_out;
    assign result.is_param      = data_reg.is_param;
    assign result.param_index   = data_reg.param_index;
    assign result.pkt_id        = data_reg.pkt_id;
    assign result.end_of_packet = data_reg.end_of_packet;
    assign result.status        = data_reg.status;

endmodule

FILE: design/packet_deframer_checksum_unit.sv
// A word taken into the input register moves on to the result register when that is
// free and is offered from there. One word per cycle while the sink takes each one;
// the only per-word work is an 8-bit add and compare.
// Reset (rst_n low, asynchronous): both stage registers empty, parser expects an id,
// id, length, count and sum cleared.
module packet_deframer_checksum_unit (
    input  logic      clk,
    input  logic      rst_n,
    pdc_rx_if.sink    rx,
    pdc_res_if.source result
);

    logic                       item_valid;
    logic [pdc_pkg::DATA_W-1:0] item_byte;
    logic                       res_free;
    logic                       advance;
    pdc_pkg::result_t           frame_res;

    // Move a word from the input register into the result register only when the
    // result register can take it; the parser state updates on the same edge, so
    // every word is parsed exactly once.
    assign advance = item_valid && res_free;

    // Input register: capture the received word, hold it under back-pressure.
    pdc_input_reg u_input_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .advance    (advance),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    // Parser: id, length, parameters, then the checksum word, which is compared
    // with the inverse of the running sum. A zero length closes the packet at once.
    pdc_frame_fsm u_frame_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item_byte (item_byte),
        .res       (frame_res)
    );

    // Result register: hold the annotated word until the sink takes it.
    pdc_result_reg u_result_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .res_in (frame_res),
        .free   (res_free),
        .result (result)
    );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    // Clock period and the watchdog. The slowest legal run is a few thousand
    // words, so this leaves a wide margin.
    localparam int unsigned CLK_PERIOD_NS = 12;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    // Extra cycles to wait after the last predicted result has come back.
    localparam int unsigned SETTLE_CYCLES = 8;

    logic clk;
    logic rst_n;

    pdc_rx_if  rx_ch ();
    pdc_res_if res_ch ();

    packet_deframer_checksum_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (res_ch)
    );

    // Idle and stall rates, in percent, for the sender and the receiver.
    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;

    // Deframer state as predicted by the testbench.
    pdc_pkg::phase_t parse_phase;
    logic [7:0]      cur_id;
    logic [7:0]      frame_len;
    logic [7:0]      param_cnt;
    logic [7:0]      csum_acc;

    // Predicted results, oldest first.
    pdc_pkg::result_t pending_results[$];

    int unsigned err_count;
    int unsigned words_sent;
    int unsigned words_checked;
    int unsigned frames_ok;
    int unsigned frames_bad_sum;
    int unsigned frames_zero_len;
    int unsigned cycle_cnt;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD_NS / 2.0) clk = ~clk;
        end
    end

    // Work out the result for one accepted word and advance the predicted
    // parser state.
    function automatic pdc_pkg::result_t predict_deframe(input logic [7:0] rx_val);
        pdc_pkg::result_t r;
        logic [7:0]       next_cnt;
        r               = '0;
        r.byte_out      = rx_val;
        r.status        = pdc_pkg::ST_OK;
        next_cnt        = param_cnt + 8'd1;
        case (parse_phase)
            pdc_pkg::PH_LEN:
            begin
                frame_len = rx_val;
                csum_acc  = csum_acc + rx_val;
                param_cnt = 8'd0;
                if (rx_val == 8'd0)
                begin
                    // Zero length: the frame is over on the length word itself.
                    r.end_of_packet = 1'b1;
                    r.status        = pdc_pkg::ST_ZERO_LEN;
                    parse_phase     = pdc_pkg::PH_ID;
                end
                else
                begin
                    parse_phase = pdc_pkg::PH_PAY;
                end
            end
            pdc_pkg::PH_PAY:
            begin
                if (next_cnt == frame_len)
                begin
                    // Last payload word is the checksum: inverse of the sum so far.
                    r.end_of_packet = 1'b1;
                    r.status        = (rx_val == ~csum_acc) ?
                                      pdc_pkg::ST_OK : pdc_pkg::ST_BAD_SUM;
                    parse_phase     = pdc_pkg::PH_ID;
                end
                else
                begin
                    r.is_param    = 1'b1;
                    r.param_index = param_cnt;
                    csum_acc      = csum_acc + rx_val;
                    param_cnt     = next_cnt;
                end
            end
            default:
            begin
                // The unused phase code behaves as the id phase.
                cur_id      = rx_val;
                csum_acc    = rx_val;
                frame_len   = 8'd0;
                param_cnt   = 8'd0;
                parse_phase = pdc_pkg::PH_LEN;
            end
        endcase
        r.pkt_id = cur_id;
        return r;
    endfunction

    // Offer one word, with a random gap in front of it, and hold it until it
    // is taken. The prediction is queued at the edge that accepts the word.
    task automatic send_word(input logic [7:0] rx_val);
        while ($urandom_range(99) < src_idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= rx_val;
        @(posedge clk);
        while (!rx_ch.ready)
        begin
            @(posedge clk);
        end
        pending_results.push_back(predict_deframe(rx_val));
        words_sent++;
    endtask

    // Send a well-formed frame with random parameter words. When corrupt is
    // set, the checksum is flipped in at least one bit.
    task automatic send_frame(input logic [7:0] id, input logic [7:0] len,
                              input bit corrupt);
        logic [7:0] sum;
        logic [7:0] param;
        int         i;
        sum = id + len;
        send_word(id);
        send_word(len);
        if (len != 8'd0)
        begin
            for (i = 0; i < int'(len) - 1; i++)
            begin
                param = 8'($urandom);
                sum   = sum + param;
                send_word(param);
            end
            if (corrupt)
            begin
                send_word(~sum ^ 8'($urandom_range(1, 255)));
            end
            else
            begin
                send_word(~sum);
            end
        end
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic drain_results();
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0d ns: %s mismatch, expected 0x%02h, actual 0x%02h",
                     $time, name, want, got);
            err_count++;
        end
    endtask

    // Zero-length frames end on the length word, with and without a
    // zero id.
    task automatic test_zero_length();
        send_word(8'h00);
        send_word(8'h00);
        send_word(8'hFF);
        send_word(8'h00);
        drain_results();
    endtask

    // Length one: the word after the length is the checksum straight away.
    task automatic test_length_one();
        send_word(8'hFF);
        send_word(8'h01);
        send_word(8'hFF);
        send_word(8'h5A);
        send_word(8'h01);
        send_word(8'h00);
        drain_results();
    endtask

    // Parameter words at the field extremes, with a sum that wraps.
    task automatic test_field_extremes();
        logic [7:0] sum;
        sum = 8'h80 + 8'h04 + 8'h00 + 8'hFF + 8'h7F;
        send_word(8'h80);
        send_word(8'h04);
        send_word(8'h00);
        send_word(8'hFF);
        send_word(8'h7F);
        send_word(~sum);
        drain_results();
    endtask

    // A bad checksum still closes the frame; the next word is an id.
    task automatic test_bad_checksum();
        logic [7:0] sum;
        sum = 8'h01 + 8'h03 + 8'hAA + 8'h55;
        send_word(8'h01);
        send_word(8'h03);
        send_word(8'hAA);
        send_word(8'h55);
        send_word(~sum + 8'd1);
        drain_results();
    endtask

    // Mostly well-formed frames with random content, some corrupted, mixed
    // with stray words that throw the framing off. One long frame per call
    // drives the upper bits of the parameter index.
    task automatic test_random_stream(input int unsigned n_words,
                                      input int unsigned src_pct,
                                      input int unsigned snk_pct,
                                      input logic [7:0]  long_len);
        int unsigned target;
        int unsigned pick;
        int unsigned n_noise;
        logic [7:0]  len;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        target        = words_sent + n_words;
        send_frame(8'($urandom), long_len, $urandom_range(1) == 0);
        while (words_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 85)
            begin
                pick = $urandom_range(99);
                if (pick < 5)
                    len = 8'd0;
                else if (pick < 20)
                    len = 8'd1;
                else
                    len = 8'($urandom_range(2, 16));
                send_frame(8'($urandom), len, $urandom_range(99) < 20);
            end
            else
            begin
                n_noise = $urandom_range(1, 4);
                repeat (n_noise) send_word(8'($urandom));
            end
        end
        drain_results();
    endtask

    // Receiver side: stall at random and check each word taken against the
    // oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0d ns: result with nothing predicted, byte_out 0x%02h",
                         $time, res_ch.byte_out);
                err_count++;
            end
            else
            begin
                pdc_pkg::result_t want;
                want = pending_results.pop_front();
                check_field("byte_out", want.byte_out, res_ch.byte_out);
                check_field("is_param", 8'(want.is_param), 8'(res_ch.is_param));
                check_field("param_index", want.param_index, res_ch.param_index);
                check_field("pkt_id", want.pkt_id, res_ch.pkt_id);
                check_field("end_of_packet", 8'(want.end_of_packet),
                            8'(res_ch.end_of_packet));
                check_field("status", 8'(want.status), 8'(res_ch.status));
                words_checked++;
                if (want.end_of_packet)
                begin
                    case (want.status)
                        pdc_pkg::ST_OK:      frames_ok++;
                        pdc_pkg::ST_BAD_SUM: frames_bad_sum++;
                        default:             frames_zero_len++;
                    endcase
                end
            end
        end
        res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Watchdog: abandon the run if it hangs.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("%0d ns: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_cnt, pending_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        // Hold every input at a known value from time zero.
        rst_n          = 1'b0;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = '0;
        res_ch.ready   = 1'b0;
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
        err_count      = 0;
        words_sent     = 0;
        words_checked  = 0;
        frames_ok      = 0;
        frames_bad_sum = 0;
        frames_zero_len = 0;
        cycle_cnt      = 0;
        // Predicted state starts as the block does out of reset.
        parse_phase    = pdc_pkg::PH_ID;
        cur_id         = 8'd0;
        frame_len      = 8'd0;
        param_cnt      = 8'd0;
        csum_acc       = 8'd0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_length();
        test_length_one();
        test_field_extremes();
        test_bad_checksum();

        // Idling phases: none, sender idle, receiver stalling, both.
        test_random_stream(500, 0, 0, 8'($urandom_range(130, 254)));
        test_random_stream(480, 53, 0, 8'($urandom_range(130, 254)));
        test_random_stream(480, 0, 53, 8'($urandom_range(130, 254)));
        test_random_stream(490, 22, 22, 8'd255);

        $display("Covered %0d words in and %0d results checked over four idling phases.",
                 words_sent, words_checked);
        $display("Frames closed: %0d good, %0d bad checksum, %0d zero length.",
                 frames_ok, frames_bad_sum, frames_zero_len);
        if (err_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: packet_deframer_checksum_unit.f
design/pdc_pkg.sv
design/pdc_rx_if.sv
design/pdc_res_if.sv
design/pdc_input_reg.sv
design/pdc_frame_fsm.sv
design/pdc_result_reg.sv
design/packet_deframer_checksum_unit.sv
tb/tb_top.sv
